// ----- src/wlat_pkg.sv -----
// Shared types and constants for the wear-levelling address translator.
// No dependencies.
package wlat_pkg;

  // Dividend width of the shared setup divider (rotation * page product)
  localparam int DIV_W = 56;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [2:0] REG_ENABLED        = 3'd0;
  localparam logic [2:0] REG_START_ADDR     = 3'd1;
  localparam logic [2:0] REG_PARTITION_SIZE = 3'd2;
  localparam logic [2:0] REG_SECTOR_BYTES   = 3'd3;
  localparam logic [2:0] REG_RECORD_BYTES   = 3'd4;
  localparam logic [2:0] REG_PAGE_BYTES     = 3'd5;
  localparam logic [2:0] REG_ROTATION_COUNT = 3'd6;
  localparam logic [2:0] REG_DUMMY_PAGE     = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_Q1_GO,
    ST_Q1_W,
    ST_MS_MUL,
    ST_MS,
    ST_SS_GO,
    ST_SS_W,
    ST_CF_GO,
    ST_CF_W,
    ST_CHK,
    ST_Q2_GO,
    ST_Q2_W,
    ST_RP_MUL,
    ST_RM_GO,
    ST_RM_W,
    ST_DA_MUL,
    ST_FIN
  } setup_state_t;

  // Layout values derived from the registers, held steady between writes
  typedef struct packed {
    logic        bypass;
    logic [31:0] k;
    logic [31:0] usable;
    logic [42:0] skip_addr;
    logic [22:0] page;
    logic [31:0] start;
  } xlat_t;

  // One restoring remainder step: shift in a bit, subtract the divisor if it fits
  function automatic logic [31:0] rem_step(input logic [31:0] r, input logic b,
                                           input logic [31:0] d);
    logic [32:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      rem_step = 32'(t - {1'b0, d});
    end else begin
      rem_step = t[31:0];
    end
  endfunction

endpackage

// ----- src/wlat_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, for the layout setup.
// Depends on wlat_pkg.
module wlat_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [wlat_pkg::DIV_W-1:0]  dividend,
  input  logic [31:0]                 divisor,
  output logic                        done,
  output logic [wlat_pkg::DIV_W-1:0]  quo,
  output logic [31:0]                 rem
);

  logic                           busy;
  logic [wlat_pkg::DIV_CNT_W-1:0] cnt;
  logic [31:0]                    d;
  logic [32:0]                    t;
  logic                           fits;

  assign t    = {rem, quo[wlat_pkg::DIV_W-1]};
  assign fits = t >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == wlat_pkg::DIV_CNT_W'(wlat_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quo doubles as the dividend shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      d   <= divisor;
    end else if (busy) begin
      rem <= wlat_pkg::rem_step(rem, quo[wlat_pkg::DIV_W-1], d);
      quo <= {quo[wlat_pkg::DIV_W-2:0], fits};
    end
  end

endmodule

// ----- src/wlat_setup.sv -----
// Configuration registers and the sequencer that derives the layout from them.
// Depends on wlat_pkg and wlat_div.
module wlat_setup #(
  parameter int STATE_HEADER_BYTES = 64,
  parameter int CONFIG_BYTES       = 36
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  output logic                  busy,
  output wlat_pkg::xlat_t       xlat
);

  logic        enabled;
  logic [31:0] base_addr;
  logic [31:0] partition_size;
  logic [12:0] sector_bytes;
  logic [12:0] record_bytes;
  logic [22:0] page_bytes;
  logic [31:0] rotation_count;
  logic [19:0] dummy_page;

  wlat_pkg::setup_state_t st, st_next;

  logic [31:0] q1;
  logic [45:0] ms;
  logic [46:0] state_sz;
  logic [13:0] cfg_sz;
  logic        impossible;
  logic [31:0] rem4;
  logic [31:0] usable;
  logic [31:0] rot_mod;
  logic [42:0] skip_addr;
  logic [31:0] k;
  logic        bypass;
  logic [54:0] mul_p;

  logic [31:0] mul_a;
  logic [22:0] mul_b;
  logic        div_start;
  logic [wlat_pkg::DIV_W-1:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [wlat_pkg::DIV_W-1:0] div_quo;
  logic [31:0] div_rem;

  logic        ss_need;
  logic [46:0] ss_num;
  logic [13:0] cf_num;
  logic [48:0] need;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled        <= 1'b0;
      base_addr      <= '0;
      partition_size <= '0;
      sector_bytes   <= 13'd4096;
      record_bytes   <= 13'd16;
      page_bytes     <= 23'd4096;
      rotation_count <= '0;
      dummy_page     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wlat_pkg::REG_ENABLED:        enabled        <= cfg_data[0];
        wlat_pkg::REG_START_ADDR:     base_addr      <= cfg_data;
        wlat_pkg::REG_PARTITION_SIZE: partition_size <= cfg_data;
        wlat_pkg::REG_SECTOR_BYTES:   sector_bytes   <= cfg_data[12:0];
        wlat_pkg::REG_RECORD_BYTES:   record_bytes   <= cfg_data[12:0];
        wlat_pkg::REG_PAGE_BYTES:     page_bytes     <= cfg_data[22:0];
        wlat_pkg::REG_ROTATION_COUNT: rotation_count <= cfg_data;
        wlat_pkg::REG_DUMMY_PAGE:     dummy_page     <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  assign ss_need = {33'd0, sector_bytes} < ms;
  assign ss_num  = 47'(ms) + 47'(sector_bytes) - 47'd1;
  assign cf_num  = 14'(CONFIG_BYTES) + 14'(sector_bytes) - 14'd1;
  assign need    = 49'({state_sz, 1'b0}) + 49'(cfg_sz) + 49'(page_bytes);

  // next state; any write restarts the pass
  always_comb begin
    st_next = st;
    case (st)
      wlat_pkg::ST_IDLE:   st_next = wlat_pkg::ST_IDLE;
      wlat_pkg::ST_Q1_GO:  st_next = wlat_pkg::ST_Q1_W;
      wlat_pkg::ST_Q1_W:   if (div_done) st_next = wlat_pkg::ST_MS_MUL;
      wlat_pkg::ST_MS_MUL: st_next = wlat_pkg::ST_MS;
      wlat_pkg::ST_MS:     st_next = wlat_pkg::ST_SS_GO;
      wlat_pkg::ST_SS_GO:  st_next = ss_need ? wlat_pkg::ST_SS_W : wlat_pkg::ST_CF_GO;
      wlat_pkg::ST_SS_W:   if (div_done) st_next = wlat_pkg::ST_CF_GO;
      wlat_pkg::ST_CF_GO:  st_next = wlat_pkg::ST_CF_W;
      wlat_pkg::ST_CF_W:   if (div_done) st_next = wlat_pkg::ST_CHK;
      wlat_pkg::ST_CHK:    st_next = wlat_pkg::ST_Q2_GO;
      wlat_pkg::ST_Q2_GO:  st_next = wlat_pkg::ST_Q2_W;
      wlat_pkg::ST_Q2_W:   if (div_done) st_next = wlat_pkg::ST_RP_MUL;
      wlat_pkg::ST_RP_MUL: st_next = wlat_pkg::ST_RM_GO;
      wlat_pkg::ST_RM_GO:  st_next = wlat_pkg::ST_RM_W;
      wlat_pkg::ST_RM_W:   if (div_done) st_next = wlat_pkg::ST_DA_MUL;
      wlat_pkg::ST_DA_MUL: st_next = wlat_pkg::ST_FIN;
      wlat_pkg::ST_FIN:    st_next = wlat_pkg::ST_IDLE;
      default:             st_next = wlat_pkg::ST_IDLE;
    endcase
    if (cfg_we) st_next = wlat_pkg::ST_Q1_GO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= wlat_pkg::ST_Q1_GO;
    end else begin
      st <= st_next;
    end
  end

  // outputs: multiplier and divider operands per state
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (st)
      wlat_pkg::ST_Q1_GO: begin
        div_start    = 1'b1;
        div_dividend = wlat_pkg::DIV_W'(partition_size);
        div_divisor  = 32'(sector_bytes);
      end
      wlat_pkg::ST_MS_MUL: begin
        mul_a = q1;
        mul_b = 23'(record_bytes);
      end
      wlat_pkg::ST_SS_GO: begin
        div_start    = ss_need;
        div_dividend = wlat_pkg::DIV_W'(ss_num);
        div_divisor  = 32'(sector_bytes);
      end
      wlat_pkg::ST_CF_GO: begin
        div_start    = 1'b1;
        div_dividend = wlat_pkg::DIV_W'(cf_num);
        div_divisor  = 32'(sector_bytes);
      end
      wlat_pkg::ST_Q2_GO: begin
        div_start    = 1'b1;
        div_dividend = wlat_pkg::DIV_W'(rem4);
        div_divisor  = 32'(page_bytes);
      end
      wlat_pkg::ST_RP_MUL: begin
        mul_a = rotation_count;
        mul_b = page_bytes;
      end
      wlat_pkg::ST_RM_GO: begin
        div_start    = 1'b1;
        div_dividend = wlat_pkg::DIV_W'(mul_p);
        div_divisor  = usable;
      end
      wlat_pkg::ST_DA_MUL: begin
        mul_a = 32'(dummy_page);
        mul_b = page_bytes;
      end
      default: ;
    endcase
  end

  wlat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    mul_p <= {23'd0, mul_a} * {32'd0, mul_b};
  end

  // round_up(v, u) is worked out as v + u - 1 minus its remainder
  always_ff @(posedge clk) begin
    case (st)
      wlat_pkg::ST_Q1_W:  if (div_done) q1 <= div_quo[31:0];
      wlat_pkg::ST_MS:    ms <= 46'(STATE_HEADER_BYTES) + mul_p[45:0];
      wlat_pkg::ST_SS_GO: if (!ss_need) state_sz <= 47'(sector_bytes);
      wlat_pkg::ST_SS_W:  if (div_done) state_sz <= ss_num - 47'(div_rem);
      wlat_pkg::ST_CF_W:  if (div_done) cfg_sz <= cf_num - div_rem[13:0];
      wlat_pkg::ST_CHK: begin
        impossible <= {17'd0, partition_size} < need;
        rem4       <= partition_size - {state_sz[30:0], 1'b0} - 32'(cfg_sz);
      end
      wlat_pkg::ST_Q2_W:  if (div_done) usable <= rem4 - div_rem - 32'(page_bytes);
      wlat_pkg::ST_RM_W:  if (div_done) rot_mod <= div_rem;
      wlat_pkg::ST_FIN: begin
        skip_addr <= mul_p[42:0];
        k         <= usable - rot_mod;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b1;
    end else if (st == wlat_pkg::ST_FIN) begin
      bypass <= !enabled || (sector_bytes == '0) || (page_bytes == '0) ||
                impossible || (usable == '0);
    end
  end

  assign busy           = st != wlat_pkg::ST_IDLE;
  assign xlat.bypass    = bypass;
  assign xlat.k         = k;
  assign xlat.usable    = usable;
  assign xlat.skip_addr = skip_addr;
  assign xlat.page      = page_bytes;
  assign xlat.start     = base_addr;

endmodule

// ----- src/wlat_front.sv -----
// Front stage: takes requests, classifies bypass vs translate, forms the rotated sum.
// Depends on wlat_pkg.
module wlat_front #(
  parameter int AW = 32,
  parameter int XW = 33
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [AW-1:0]        logical_addr,
  input  logic                 busy,
  input  wlat_pkg::xlat_t      xlat,
  input  logic                 fifo_full,
  output logic                 push,
  output logic [XW-1:0]        push_x,
  output logic                 push_bypass
);

  logic          fv;
  logic [XW-1:0] fx;
  logic          fb;
  logic          accept;

  assign in_stall    = busy || (fv && fifo_full);
  assign accept      = in_valid && !in_stall;
  assign push        = fv && !fifo_full;
  assign push_x      = fx;
  assign push_bypass = fb;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else begin
      fv <= accept || (fv && !push);
    end
  end

  // bypassed requests carry the raw address in the same field
  always_ff @(posedge clk) begin
    if (accept) begin
      fb <= xlat.bypass;
      fx <= xlat.bypass ? XW'(logical_addr) : XW'(logical_addr) + XW'(xlat.k);
    end
  end

endmodule

// ----- src/wlat_fifo.sv -----
// Two-entry queue between the front and back stages.
// No package dependencies.
module wlat_fifo #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         nonempty
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  assign dout     = mem[rp];
  assign full     = cnt == 2'd2;
  assign nonempty = cnt != 2'd0;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue written while full");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count out of range");
  a_cnt_inc: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt == $past(cnt) + 2'd1)
    else $error("queue count lost a write");
  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    (push == pop) |=> cnt == $past(cnt))
    else $error("queue count moved without cause");

endmodule

// ----- src/wlat_back.sv -----
// Back stage: pipelined modulo by the usable size, dummy-page skip and base add.
// Depends on wlat_pkg.
module wlat_back #(
  parameter int XW = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fifo_valid,
  input  logic [XW-1:0]    fifo_x,
  input  logic             fifo_bypass,
  output logic             pop,
  input  wlat_pkg::xlat_t  xlat,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [32:0]      physical_addr,
  output logic             passthrough
);

  logic          en;
  logic [XW-1:0] sv;
  logic [31:0]   sr [XW];
  logic [XW-1:0] sx [XW];
  logic [XW-1:0] sb;
  logic          va;
  logic          ba;
  logic [32:0]   offa;
  logic [32:0]   xa;

  // whole pipe moves together unless the output register is held
  assign en  = !out_valid || !out_stall;
  assign pop = en && fifo_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv        <= '0;
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      sv        <= {sv[XW-2:0], fifo_valid};
      va        <= sv[XW-1];
      out_valid <= va;
    end
  end

  // one remainder bit per stage, MSB first
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= wlat_pkg::rem_step(32'd0, fifo_x[XW-1], xlat.usable);
      sx[0] <= fifo_x;
      sb[0] <= fifo_bypass;
      for (int i = 1; i < XW; i++) begin
        sr[i] <= wlat_pkg::rem_step(sr[i-1], sx[i-1][XW-1-i], xlat.usable);
        sx[i] <= sx[i-1];
        sb[i] <= sb[i-1];
      end
      ba   <= sb[XW-1];
      xa   <= sx[XW-1][32:0];
      offa <= (43'(sr[XW-1]) >= xlat.skip_addr) ?
              33'(sr[XW-1]) + 33'(xlat.page) : 33'(sr[XW-1]);
      passthrough   <= ba;
      physical_addr <= ba ? xa : 33'(xlat.start) + offa;
    end
  end

endmodule

// ----- src/wear_level_address_translate_core.sv -----
// Wear-levelling address translator: logical flash byte address in, physical out.
// Takes one request per cycle while in_stall is low; a result passes the front register,
// the queue, one remainder stage per sum bit and the skip/base adders, and is held at
// the output while out_stall is high. After reset and after every register write,
// an iterative divider rebuilds the layout (up to five divisions) and in_stall stays high
// until it is done.
// Depends on wlat_pkg, wlat_setup, wlat_front, wlat_fifo and wlat_back.
module wear_level_address_translate_core #(
  parameter int ADDR_WIDTH         = 32,
  parameter int STATE_HEADER_BYTES = 64,
  parameter int CONFIG_BYTES       = 36
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_WIDTH-1:0] logical_addr,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [32:0]           physical_addr,
  output logic                  passthrough,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam int XW = ((ADDR_WIDTH > 32) ? ADDR_WIDTH : 32) + 1;

  logic            busy;
  wlat_pkg::xlat_t xlat;
  logic            fifo_full;
  logic            fifo_nonempty;
  logic            push;
  logic [XW-1:0]   push_x;
  logic            push_bypass;
  logic            pop;
  logic [XW:0]     fifo_dout;

  wlat_setup #(
    .STATE_HEADER_BYTES (STATE_HEADER_BYTES),
    .CONFIG_BYTES       (CONFIG_BYTES)
  ) u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .xlat      (xlat)
  );

  wlat_front #(
    .AW (ADDR_WIDTH),
    .XW (XW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .logical_addr (logical_addr),
    .busy         (busy),
    .xlat         (xlat),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_x       (push_x),
    .push_bypass  (push_bypass)
  );

  wlat_fifo #(
    .W (XW + 1)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      ({push_bypass, push_x}),
    .pop      (pop),
    .dout     (fifo_dout),
    .full     (fifo_full),
    .nonempty (fifo_nonempty)
  );

  wlat_back #(
    .XW (XW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .fifo_valid    (fifo_nonempty),
    .fifo_x        (fifo_dout[XW-1:0]),
    .fifo_bypass   (fifo_dout[XW]),
    .pop           (pop),
    .xlat          (xlat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .physical_addr (physical_addr),
    .passthrough   (passthrough)
  );

endmodule

// ----- test/tb.sv -----
// Self-checking bench for wear_level_address_translate_core: random layouts, random addresses.
// Holds its own translation predictor; depends on wlat_pkg and the core RTL.
module tb;

  typedef struct {
    logic [32:0] phys;
    logic        pt;
  } xlat_res_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] logical_addr = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [32:0] physical_addr;
  logic        passthrough;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = wlat_pkg::REG_ENABLED;
  logic [31:0] cfg_data = '0;

  wear_level_address_translate_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .logical_addr(logical_addr),
    .out_valid(out_valid), .out_stall(out_stall),
    .physical_addr(physical_addr), .passthrough(passthrough),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // register mirror
  logic        m_en;
  logic [31:0] m_start, m_part, m_rot;
  logic [12:0] m_sec, m_rec;
  logic [22:0] m_page;
  logic [19:0] m_dummy;

  xlat_res_t   pending_xlat[$];
  int          n_err = 0, n_req = 0, n_res = 0, n_trans = 0, n_layouts = 0;
  int          wd_cnt = 0;
  bit          calm = 0;
  int          rx_hold = 0;

  initial forever #1 clk = ~clk;

  function automatic void translate(input logic [31:0] a, output xlat_res_t r);
    longint unsigned ss, ms, cf, us, off, da, sec, pg, part;
    r.phys = {1'b0, a};
    r.pt   = 1'b1;
    sec  = m_sec;
    pg   = m_page;
    part = m_part;
    if (!m_en || sec == 0 || pg == 0) return;
    ss = sec;
    ms = 64 + (part / sec) * longint'(m_rec);
    if (ss < ms) ss = ((ms + sec - 1) / sec) * sec;
    cf = ((36 + sec - 1) / sec) * sec;
    if (part < ss * 2 + cf + pg) return;
    us = ((part - ss * 2 - cf) / pg - 1) * pg;
    if (us == 0) return;
    off = (us - (longint'(m_rot) * pg) % us + longint'(a)) % us;
    da  = longint'(m_dummy) * pg;
    if (off >= da) off += pg;
    r.phys = 33'(longint'(m_start) + off);
    r.pt   = 1'b0;
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_addr(input logic [31:0] a);
    int gap;
    xlat_res_t r;
    gap = draw_wait();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    logical_addr <= a;
    do @(posedge clk); while (in_stall);
    translate(a, r);
    pending_xlat.push_back(r);
    n_req++;
  endtask

  // wait until every translation is back, then let the pipeline settle
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_xlat.size() > 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      wlat_pkg::REG_ENABLED:        m_en    = d[0];
      wlat_pkg::REG_START_ADDR:     m_start = d;
      wlat_pkg::REG_PARTITION_SIZE: m_part  = d;
      wlat_pkg::REG_SECTOR_BYTES:   m_sec   = d[12:0];
      wlat_pkg::REG_RECORD_BYTES:   m_rec   = d[12:0];
      wlat_pkg::REG_PAGE_BYTES:     m_page  = d[22:0];
      wlat_pkg::REG_ROTATION_COUNT: m_rot   = d;
      default:                      m_dummy = d[19:0];
    endcase
  endtask

  task automatic set_layout(input logic en, input logic [31:0] st, input logic [31:0] part,
                            input logic [31:0] sec, input logic [31:0] rec,
                            input logic [31:0] pg, input logic [31:0] rot,
                            input logic [31:0] dp);
    drain();
    write_reg(wlat_pkg::REG_ENABLED, {31'b0, en});
    write_reg(wlat_pkg::REG_START_ADDR, st);
    write_reg(wlat_pkg::REG_PARTITION_SIZE, part);
    write_reg(wlat_pkg::REG_SECTOR_BYTES, sec);
    write_reg(wlat_pkg::REG_RECORD_BYTES, rec);
    write_reg(wlat_pkg::REG_PAGE_BYTES, pg);
    write_reg(wlat_pkg::REG_ROTATION_COUNT, rot);
    write_reg(wlat_pkg::REG_DUMMY_PAGE, dp);
    n_layouts++;
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_res++;
      if (pending_xlat.size() == 0) begin
        $error("unexpected result phys=%h pt=%b", physical_addr, passthrough);
        n_err++;
      end else begin
        if (physical_addr !== pending_xlat[0].phys) begin
          $error("physical_addr expected %h actual %h", pending_xlat[0].phys, physical_addr);
          n_err++;
        end
        if (passthrough !== pending_xlat[0].pt) begin
          $error("passthrough expected %b actual %b", pending_xlat[0].pt, passthrough);
          n_err++;
        end
        if (!pending_xlat[0].pt) n_trans++;
        void'(pending_xlat.pop_front());
      end
      rx_hold <= draw_wait();
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold   <= rx_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || rst) wd_cnt <= 0;
    else wd_cnt <= wd_cnt + 1;
    if (wd_cnt >= 5000) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    m_en = 0; m_start = 0; m_part = 0; m_sec = 4096; m_rec = 16; m_page = 4096;
    m_rot = 0; m_dummy = 0;
    send_addr(32'h0);
    send_addr(32'hFFFF_FFFF);
  endtask

  task automatic test_directed();
    // plain layout: 1 MiB partition, 4 KiB pages, dummy in the middle
    set_layout(1, 32'h1000_0000, 32'h0010_0000, 4096, 16, 4096, 3, 100);
    send_addr(32'h0);
    send_addr(32'h0006_3FFF);   // dummy page offset minus one, before rotation
    send_addr(32'h0006_4000);   // dummy page offset, before rotation
    send_addr(32'hFFFF_FFFF);   // wraps
    send_addr(32'h000E_0000);
    // disabled
    set_layout(0, 32'h1234_5678, 32'h0010_0000, 4096, 16, 4096, 3, 100);
    send_addr(32'hDEAD_BEEF);
    // zero sector and zero page
    set_layout(1, 0, 32'h0010_0000, 0, 16, 4096, 0, 0);
    send_addr(32'h0000_1234);
    set_layout(1, 0, 32'h0010_0000, 4096, 16, 0, 0, 0);
    send_addr(32'h0000_1234);
    // impossible layout
    set_layout(1, 0, 32'h0000_3000, 4096, 16, 4096, 0, 0);
    send_addr(32'h0000_0010);
    // zero usable: exactly one page after the overhead
    set_layout(1, 0, 32'h0000_4000, 4096, 16, 4096, 0, 0);
    send_addr(32'h0000_0010);
    // dummy beyond usable area, full-scale start and rotation
    set_layout(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 512, 1, 4194304, 32'hFFFF_FFFF, 20'hFFFFF);
    send_addr(32'h8000_0000);
    send_addr(32'hFFFF_FFFF);
    // 4096-byte record, 512-byte sector
    set_layout(1, 32'h0, 32'h0800_0000, 512, 4096, 512, 7, 5);
    send_addr(32'h0000_0200);
    // values wider than the sector, record, page and dummy fields
    set_layout(1, 32'hAAAA_5555, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'h5555_AAAA, 32'hFFFF_FFFF);
    send_addr(32'h1357_9BDF);
  endtask

  task automatic test_random_layouts();
    logic [31:0] sec, rec, pg, part, dp, a;
    int n;
    for (int l = 0; l < 30; l++) begin
      sec = $urandom_range(512, 4096);
      rec = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 32);
      pg  = ($urandom_range(0, 5) == 0) ? 512 * $urandom_range(1, 8192)
                                        : 512 * $urandom_range(1, 64);
      case ($urandom_range(0, 3))
        0: part = $urandom();
        1: part = 3 * sec + pg * $urandom_range(0, 4);
        default: part = 4 * sec + 8192 + pg * $urandom_range(2, 2000);
      endcase
      dp = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, part / pg + 2);
      set_layout($urandom_range(0, 9) != 0, $urandom(), part, sec, rec, pg, $urandom(), dp);
      calm = ($urandom_range(0, 4) == 0);
      n = $urandom_range(45, 65);
      for (int i = 0; i < n; i++) begin
        a = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, part);
        send_addr(a);
        if (l == 5 && i == n / 2) drain();   // sender holds off mid-phase
      end
      calm = 0;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_reset_defaults();
    test_directed();
    test_random_layouts();
    drain();
    $display("covered %0d layouts, %0d requests, %0d results (%0d translated)",
             n_layouts, n_req, n_res, n_trans);
    if (n_err == 0 && pending_xlat.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

// ----- wear_level_address_translate_core.f -----
src/wlat_pkg.sv
src/wlat_div.sv
src/wlat_setup.sv
src/wlat_front.sv
src/wlat_fifo.sv
src/wlat_back.sv
src/wear_level_address_translate_core.sv
test/tb.sv
